>>> design/assert_macros.svh
// Assertion macros shared by the encoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rse_pkg.sv
// Package for the Reed-Solomon encoder: field constants, generator table, entry types.
// No dependencies.
package rse_pkg;

	localparam int NGEN = 16;
	localparam logic [8:0] FIELD_POLY = 9'h11d;

	localparam int IDX_W = (NGEN > 1) ? $clog2(NGEN) : 1;
	localparam int PH_W = $clog2(NGEN + 1);
	localparam logic [7:0] LONG_LIMIT = 8'(255 - NGEN);
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(NGEN);

	typedef logic [NGEN:0][7:0] gen_t;
	typedef logic [NGEN-1:0][7:0] par_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       flag;
		logic       last;
		par_t       parity;
	} entry_t;

	// GF(2^8) multiply, reduced by the low byte of the field polynomial.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] acc;
		x = a;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ FIELD_POLY[7:0]) : {x[6:0], 1'b0};
		end
		return acc;
	endfunction

	// Generator polynomial (x + a^0)...(x + a^(NGEN-1)), coefficient k at index k.
	function automatic gen_t build_gen();
		gen_t g;
		logic [7:0] root;
		g = '0;
		g[0] = 8'd1;
		root = 8'd1;
		for (int i = 0; i < NGEN; i++) begin
			for (int k = i + 1; k >= 1; k--) begin
				g[k] = g[k-1] ^ gf_mul(root, g[k]);
			end
			g[0] = gf_mul(root, g[0]);
			root = gf_mul(root, 8'd2);
		end
		return g;
	endfunction

	localparam gen_t GEN_COEF = build_gen();

endpackage

>>> design/rse_if.sv
// Stream interfaces for message bytes in and codeword bytes out.
// No dependencies.
interface rse_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface rse_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_parity;
	logic       end_of_codeword;
	logic       too_long;

	modport source (output valid, output out_byte, output is_parity,
		output end_of_codeword, output too_long, input ready);
	modport sink (input valid, input out_byte, input is_parity,
		input end_of_codeword, input too_long, output ready);
endinterface

>>> design/rse_front.sv
// Front part: accepts message bytes, runs the remainder LFSR and the length count.
// Depends on rse_pkg, rse_if and assert_macros.svh.
`include "assert_macros.svh"

module rse_front (
	input  logic               clk,
	input  logic               arst_n,
	rse_msg_if.sink            msg,
	input  logic               q_ready,
	output logic               push,
	output rse_pkg::entry_t    push_entry
);

	rse_pkg::par_t par_q;
	rse_pkg::par_t par_nxt;
	logic [7:0]    cnt_q;
	logic [7:0]    cnt_nxt;
	logic [7:0]    fb;
	logic          flag;

	assign msg.ready = q_ready;
	assign push = msg.valid & q_ready;

	always_comb begin
		cnt_nxt = (cnt_q == 8'hff) ? cnt_q : cnt_q + 8'd1;
		flag = cnt_nxt > rse_pkg::LONG_LIMIT;
		fb = msg.data_byte ^ par_q[rse_pkg::NGEN-1];
		par_nxt[0] = rse_pkg::gf_mul(fb, rse_pkg::GEN_COEF[0]);
		for (int k = 1; k < rse_pkg::NGEN; k++) begin
			par_nxt[k] = par_q[k-1] ^ rse_pkg::gf_mul(fb, rse_pkg::GEN_COEF[k]);
		end
	end

	always_comb begin
		push_entry.data_byte = msg.data_byte;
		push_entry.flag = flag;
		push_entry.last = msg.last;
		push_entry.parity = par_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= '0;
			cnt_q <= '0;
		end else if (push) begin
			if (msg.last) begin
				par_q <= '0;
				cnt_q <= '0;
			end else begin
				par_q <= par_nxt;
				cnt_q <= cnt_nxt;
			end
		end
	end

	`RSE_ASSERT_NEXT(a_clear_after_last, clk, arst_n, push && msg.last,
		cnt_q == 8'd0 && par_q == '0, "state not cleared after last byte")

endmodule

>>> design/rse_queue.sv
// Two-entry queue between the LFSR front and the output sequencer.
// Depends on rse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rse_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rse_pkg::entry_t push_entry,
	output logic            not_full,
	output logic            head_vld,
	output rse_pkg::entry_t head,
	input  logic            pop
);

	rse_pkg::entry_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign not_full = cnt_q != 2'd2;
	assign head_vld = cnt_q != 2'd0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`RSE_ASSERT_NOW(a_no_overflow, clk, arst_n, 1'b1, cnt_q <= 2'd2, "queue count out of range")
	`RSE_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, head_vld, "pop from empty queue")

endmodule

>>> design/rse_back.sv
// Back part: emits the message byte, then on the last byte the parity bytes.
// Depends on rse_pkg, rse_if and assert_macros.svh.
`include "assert_macros.svh"

module rse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_vld,
	input  rse_pkg::entry_t head,
	output logic            pop,
	rse_code_if.source      code
);

	logic [rse_pkg::PH_W-1:0]  phase_q;
	logic [rse_pkg::PH_W-1:0]  idx_full;
	logic [rse_pkg::IDX_W-1:0] idx;
	logic                      advance;
	logic                      done;
	logic                      ovld_q;
	logic [7:0]                obyte_q;
	logic                      opar_q;
	logic                      oeoc_q;
	logic                      olong_q;

	assign advance = !ovld_q || code.ready;
	assign done = (phase_q == '0 && !head.last) || phase_q == rse_pkg::PH_LAST;
	assign pop = advance && head_vld && done;
	assign idx_full = rse_pkg::PH_LAST - phase_q;
	assign idx = idx_full[rse_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
			phase_q <= '0;
		end else if (advance) begin
			ovld_q <= head_vld;
			if (head_vld) begin
				phase_q <= done ? '0 : phase_q + rse_pkg::PH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_vld) begin
			olong_q <= head.flag;
			if (phase_q == '0) begin
				obyte_q <= head.data_byte;
				opar_q <= 1'b0;
				oeoc_q <= 1'b0;
			end else begin
				obyte_q <= head.parity[idx];
				opar_q <= 1'b1;
				oeoc_q <= phase_q == rse_pkg::PH_LAST;
			end
		end
	end

	assign code.valid = ovld_q;
	assign code.out_byte = obyte_q;
	assign code.is_parity = opar_q;
	assign code.end_of_codeword = oeoc_q;
	assign code.too_long = olong_q;

	`RSE_ASSERT_NOW(a_phase_range, clk, arst_n, phase_q != '0,
		head_vld && head.last && phase_q <= rse_pkg::PH_LAST, "parity phase without last entry")
	`RSE_ASSERT_NOW(a_eoc_parity, clk, arst_n, ovld_q && oeoc_q, opar_q,
		"end of codeword on a non-parity byte")

endmodule

>>> design/reed_solomon_encoder_unit.sv
// Top level of the systematic Reed-Solomon encoder over GF(2^8).
// Depends on rse_pkg, rse_if, rse_front, rse_queue and rse_back.
//
//   channel | dir | request contents
//   --------+-----+------------------------------------------------------
//   msg     | in  | data_byte, last
//   code    | out | out_byte, is_parity, end_of_codeword, too_long
//
// A message byte is taken whenever the queue has room: the LFSR with its
// constant field multipliers updates in the same cycle, and a snapshot goes
// into a two-entry queue. The output sequencer sends one request per cycle
// while the receiver is ready: one per message byte, plus NGEN parity bytes
// after the last one, so a last byte stalls the input once the queue fills.
// Reset clears the LFSR, the length count, the queue pointers and the output valid flag.
// Either side may stall; the queue and output register hold everything.
module reed_solomon_encoder_unit (
	input  logic         clk,
	input  logic         arst_n,
	rse_msg_if.sink      msg,
	rse_code_if.source   code
);

	logic            q_ready;
	logic            push;
	rse_pkg::entry_t push_entry;
	logic            head_vld;
	rse_pkg::entry_t head;
	logic            pop;

	// Accept bytes and advance the remainder register.
	rse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.q_ready    (q_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decouple the byte rate in from the parity burst out.
	rse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (q_ready),
		.head_vld   (head_vld),
		.head       (head),
		.pop        (pop)
	);

	// Drain entries as codeword bytes.
	rse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head     (head),
		.pop      (pop),
		.code     (code)
	);

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for reed_solomon_encoder_unit: directed and random message streams against a
// GF(2^8) LFSR predictor kept in this file. Depends on rse_pkg, rse_if and the encoder RTL.
module tb_top;

	localparam int NGEN = rse_pkg::NGEN;
	// Low byte of the field polynomial; bit 8 is implied by the shift out of the top.
	localparam logic [7:0] REDUCE = rse_pkg::FIELD_POLY[7:0];
	// A message longer than this many bytes gets flagged as overlong.
	localparam int LONG_AT = 255 - NGEN;
	// Least number of random short-message bytes; the one overlong message comes on top of these.
	localparam int RANDOM_BYTES = 48;
	// Cycles to let pass once the last codeword byte has come, for stray requests.
	localparam int DRAIN_CYCLES = NGEN + 8;
	// Worst case is far below this: at most 17 results per byte.
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		logic [7:0] data;
		logic       tail;
	} msg_req_t;

	typedef struct {
		logic [7:0] sym;
		logic       parity;
		logic       eoc;
		logic       overlong;
	} code_sym_t;

	// Content styles for a random message.
	typedef enum int {FILL_ZERO, FILL_ONES, FILL_EXTREME, FILL_RANDOM} fill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Testbench-owned copies of the block inputs, known from time zero.
	logic       drv_valid = 1'b0;
	logic [7:0] drv_byte = 8'h00;
	logic       drv_last = 1'b0;
	logic       mon_ready = 1'b0;

	rse_msg_if  msg_ch ();
	rse_code_if code_ch ();

	assign msg_ch.valid = drv_valid;
	assign msg_ch.data_byte = drv_byte;
	assign msg_ch.last = drv_last;
	assign code_ch.ready = mon_ready;

	reed_solomon_encoder_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.code   (code_ch)
	);

	// Predictor state: generator coefficients, remainder register and length count.
	logic [7:0] gen_poly [NGEN+1];
	logic [7:0] lfsr [NGEN];
	logic [7:0] msg_len = 8'h00;

	msg_req_t  msg_backlog [$];
	code_sym_t code_expect [$];

	int  errors = 0;
	int  total_bytes = 0;
	int  bytes_taken = 0;
	int  drv_hold = 0;
	int  mon_hold = 0;
	bit  drv_calm = 1'b0;
	bit  mon_calm = 1'b0;
	int  cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// GF(2^8) product, Horner style from the top bit of b down.
	function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 7; i >= 0; i--) begin
			acc = {acc[6:0], 1'b0} ^ (acc[7] ? REDUCE : 8'h00);
			if (b[i]) begin
				acc = acc ^ a;
			end
		end
		return acc;
	endfunction

	// Multiply out (x + 2^0)(x + 2^1)...(x + 2^(NGEN-1)); gen_poly[k] holds x^k.
	function automatic void build_gen_poly();
		logic [7:0] prev [NGEN+1];
		logic [7:0] root;
		foreach (gen_poly[k]) begin
			gen_poly[k] = 8'h00;
		end
		gen_poly[0] = 8'h01;
		root = 8'h01;
		for (int i = 0; i < NGEN; i++) begin
			prev = gen_poly;
			gen_poly[0] = field_mul(prev[0], root);
			for (int k = 1; k <= NGEN; k++) begin
				gen_poly[k] = prev[k-1] ^ field_mul(prev[k], root);
			end
			root = field_mul(root, 8'h02);
		end
	endfunction

	// Append one codeword byte to the expected stream.
	function automatic void add_expect(input code_sym_t s);
		code_expect = {code_expect, s};
	endfunction

	// Advance the remainder by one message byte and queue the codeword bytes it yields.
	function automatic void rs_encode_byte(input logic [7:0] d, input logic tail);
		logic [7:0] fb;
		logic       flag;
		if (msg_len != 8'hff) begin
			msg_len = msg_len + 8'h01;
		end
		flag = (int'(msg_len) > LONG_AT);
		fb = d ^ lfsr[NGEN-1];
		for (int k = NGEN - 1; k >= 1; k--) begin
			lfsr[k] = lfsr[k-1] ^ field_mul(fb, gen_poly[k]);
		end
		lfsr[0] = field_mul(fb, gen_poly[0]);
		add_expect('{d, 1'b0, 1'b0, flag});
		if (tail) begin
			// Emit parity highest degree first, then clear for the next message.
			for (int k = NGEN - 1; k >= 0; k--) begin
				add_expect('{lfsr[k], 1'b1, k == 0, flag});
			end
			foreach (lfsr[k]) begin
				lfsr[k] = 8'h00;
			end
			msg_len = 8'h00;
		end
	endfunction

	// Draw the idle cycles for one request; now and then flip into or out of a calm stretch.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : int'($urandom_range(0, 10));
	endfunction

	task automatic queue_byte(input logic [7:0] d, input logic tail);
		msg_req_t r;
		r = '{d, tail};
		msg_backlog = {msg_backlog, r};
	endtask

	task automatic queue_message(input int len);
		fill_t      fill;
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: fill = FILL_ZERO;
			1: fill = FILL_ONES;
			2: fill = FILL_EXTREME;
			default: fill = FILL_RANDOM;
		endcase
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hff;
				FILL_EXTREME: b = $urandom_range(0, 1) ? 8'hff : 8'h00;
				default: b = 8'($urandom_range(0, 255));
			endcase
			queue_byte(b, i == len - 1);
		end
	endtask

	// Message driver: present the backlog one request at a time, idling between requests.
	always @(posedge clk or negedge arst_n) begin : msg_driver
		msg_req_t nxt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_byte <= 8'h00;
			drv_last <= 1'b0;
		end else begin
			// Predict on the accepted request, then draw the gap before the next one.
			if (drv_valid && msg_ch.ready) begin
				rs_encode_byte(drv_byte, drv_last);
				bytes_taken++;
				drv_hold = draw_wait(drv_calm);
			end
			// Hold the request while stalled; otherwise idle or advance to the next.
			if (!drv_valid || msg_ch.ready) begin
				if (drv_hold > 0) begin
					drv_hold--;
					drv_valid <= 1'b0;
				end else if (msg_backlog.size() != 0) begin
					nxt = msg_backlog.pop_front();
					drv_valid <= 1'b1;
					drv_byte <= nxt.data;
					drv_last <= nxt.tail;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Codeword monitor: check each accepted request against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : code_monitor
		code_sym_t got;
		code_sym_t want;
		if (!arst_n) begin
			mon_ready <= 1'b0;
		end else begin
			if (code_ch.valid && mon_ready) begin
				got = '{code_ch.out_byte, code_ch.is_parity, code_ch.end_of_codeword,
					code_ch.too_long};
				if (code_expect.size() == 0) begin
					errors++;
					$display("%0t: codeword request with nothing pending: byte=%02h par=%0b eoc=%0b long=%0b",
						$time, got.sym, got.parity, got.eoc, got.overlong);
				end else begin
					want = code_expect.pop_front();
					if (got.sym !== want.sym || got.parity !== want.parity ||
						got.eoc !== want.eoc || got.overlong !== want.overlong) begin
						errors++;
						$display("%0t: expected byte=%02h par=%0b eoc=%0b long=%0b",
							$time, want.sym, want.parity, want.eoc, want.overlong);
						$display("%0t:   actual byte=%02h par=%0b eoc=%0b long=%0b",
							$time, got.sym, got.parity, got.eoc, got.overlong);
					end
				end
				mon_hold = draw_wait(mon_calm);
			end
			// Drop ready for the drawn stall, then take requests again.
			if (mon_hold > 0) begin
				mon_hold--;
				mon_ready <= 1'b0;
			end else begin
				mon_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run as failed once the cycle count passes the limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int n_msgs;
		int long_slot;
		int len;
		int random_bytes;

		build_gen_poly();
		foreach (lfsr[k]) begin
			lfsr[k] = 8'h00;
		end

		// Directed: one-byte messages at both extremes, mixed bits, all ones, all zeros.
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hff, 1'b1);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'haa, 1'b0);
		queue_byte(8'h55, 1'b1);
		for (int i = 0; i < 5; i++) begin
			queue_byte(8'hff, i == 4);
		end
		for (int i = 0; i < 3; i++) begin
			queue_byte(8'h00, i == 2);
		end
		queue_byte(8'h7f, 1'b0);
		queue_byte(8'hfe, 1'b0);
		queue_byte(8'h01, 1'b1);

		// Random: short messages of random length and content. One message runs
		// past the length limit and on past the point where the count saturates,
		// so the flag rises mid-message and must clear on the next one.
		n_msgs = 0;
		random_bytes = 0;
		long_slot = $urandom_range(1, 2);
		while (random_bytes < RANDOM_BYTES || n_msgs <= long_slot + 1) begin
			if (n_msgs == long_slot) begin
				queue_message($urandom_range(256, 262));
			end else begin
				len = ($urandom_range(0, 3) == 0) ? 1 : int'($urandom_range(1, 24));
				queue_message(len);
				random_bytes += len;
			end
			n_msgs++;
		end
		total_bytes = msg_backlog.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Hold until every message byte is in and every codeword byte has come back.
		while (bytes_taken < total_bytes || code_expect.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/rse_pkg.sv
design/rse_if.sv
design/rse_front.sv
design/rse_queue.sv
design/rse_back.sv
design/reed_solomon_encoder_unit.sv
test/tb_top.sv
